>>> rtl/assert_macros.svh
// Assertion macros used by the checker file kht_checker.
// Each macro expands to one labeled concurrent assertion on the rising clock,
// with the check suspended while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define KHT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define KHT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/kht_pkg.sv
// ----------------------------------------------------------------------------
// kht_pkg
// Shared types, sizes and codes of the kernel handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package kht_pkg;

	// Table geometry
	localparam int SLOTS    = 64;
	localparam int OBJ_BITS = 16;
	localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Handle layout: bit 31 special, bit 30 owner, 29..16 instance,
	// bit 15 no-close flag, 14..0 slot index
	localparam int HDL_W    = 32;
	localparam int INST_W   = 14;
	localparam int IDXF_W   = 15;
	localparam int OBJF_W   = 16;

	// Free-slot search groups
	localparam int GRP      = 8;
	localparam int GRP_W    = $clog2(GRP);
	localparam int NGRP     = (SLOTS + GRP - 1) / GRP;
	localparam int NGRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;

	// Configuration port
	localparam int CFG_AW   = 3;
	localparam logic REG_OWNER = 1'b0;   // word index of owner_is_thread

	// Opcodes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_DUP    = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_CLOSE  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_BAD       = 2'd2;
	localparam logic [1:0] ST_NOT_LOCAL = 2'd3;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [HDL_W-1:0]  handle_in;
		logic [OBJF_W-1:0] object_ref;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [HDL_W-1:0]  handle_out;
		logic [OBJF_W-1:0] object_out;
		logic              ref_taken;
		logic              ref_dropped;
	} rsp_t;

	typedef struct packed {
		logic [HDL_W-1:0]    handle;
		logic [OBJ_BITS-1:0] obj;
	} slot_ent_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] idx;
	} free_slot_t;

endpackage

`default_nettype wire

>>> rtl/kht_free_find.sv
// ----------------------------------------------------------------------------
// kht_free_find
// Two-level search for the lowest free slot: per-group results registered,
// group select in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kht_free_find
	import kht_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [SLOTS-1:0] in_use,
	output free_slot_t            free
);

	logic [NGRP*GRP-1:0]    free_pad;
	logic [NGRP-1:0]        grp_any;
	logic [GRP_W-1:0]       grp_idx [NGRP];
	logic [NGRP-1:0]        grp_any_q;
	logic [GRP_W-1:0]       grp_idx_q [NGRP];
	logic [NGRP_W-1:0]      sel;
	logic [NGRP_W+GRP_W-1:0] flat;

	// pad slots beyond the table as taken
	always_comb begin
		free_pad = '0;
		free_pad[SLOTS-1:0] = ~in_use;
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any[g] = |free_pad[g*GRP +: GRP];
			grp_idx[g] = '0;
			for (int j = GRP - 1; j >= 0; j--) begin
				if (free_pad[g*GRP + j]) begin
					grp_idx[g] = GRP_W'(j);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_any_q <= '0;
		end else begin
			grp_any_q <= grp_any;
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			grp_idx_q[g] <= grp_idx[g];
		end
	end

	// lowest group with a free slot
	always_comb begin
		sel = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				sel = NGRP_W'(g);
			end
		end
		flat       = {sel, grp_idx_q[sel]};
		free.found = |grp_any_q;
		free.idx   = SLOT_W'(flat);
	end

endmodule

`default_nettype wire

>>> rtl/kernel_handle_table.sv
// Flow: a request accepted at a clock edge moves through stage 1, stage 2 and the
//   result register, which strobes it (done high for exactly one cycle).
// Accept: busy holds off a new request in the cycle after each accept, set
//   by the slot memory read followed by its write-back.
// Reset: slot flags, instance counter and owner bit clear at once; no clearing
//   pass, the slot memory is only read behind a set flag. Results cannot stall.
// ----------------------------------------------------------------------------
// kernel_handle_table
// Kernel object handle table with fixed slots and a wrapping 14-bit instance
// counter; add, duplicate, lookup and close of handles.
// ----------------------------------------------------------------------------
`default_nettype none

module kernel_handle_table
	import kht_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	// request channel
	input  wire logic              start,
	input  wire req_t              req,
	output logic                   busy,
	// result channel
	output logic                   done,
	output rsp_t                   rsp
);

	// ------------------------------------------------------------------
	// Configuration: a single register, owner_is_thread, at word 0.
	// The register decode uses only the word-select bit; the low two
	// address bits pick a byte lane and are ignored.
	// ------------------------------------------------------------------
	logic owner_q;
	logic cfg_wr;
	logic cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = (paddr[CFG_AW-1] == REG_OWNER);
	assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
	assign prdata  = cfg_hit ? {31'd0, owner_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= 1'b0;
		end else if (cfg_wr) begin
			owner_q <= pwdata[0];
		end
	end

	// ------------------------------------------------------------------
	// Request flow
	//   accept edge : latch request, issue slot memory read at the handle's
	//                 index
	//   stage 1     : read data back (with forwarding); validate handle;
	//                 first-level free-slot search registers
	//   stage 2     : pick free slot, build result, write memory, update flags
	// A new request may be accepted during stage 2; its memory read lands
	// on the same edge as the write-back, so the written entry is forwarded.
	// ------------------------------------------------------------------
	logic       acc;
	logic       vld_s1;
	req_t       req_s1;

	assign acc  = start && !busy;
	assign busy = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1 <= req;
		end
	end

	// ------------------------------------------------------------------
	// Slot memory: handle and object per slot, one write and one read port
	// ------------------------------------------------------------------
	slot_ent_t         slot_mem [SLOTS];
	slot_ent_t         rd_q;
	slot_ent_t         fwd_ent_q;
	logic              fwd_q;
	logic [SLOT_W-1:0] rd_idx;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_idx;
	slot_ent_t         wr_ent;
	slot_ent_t         rd_ent;

	assign rd_idx = req.handle_in[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_idx] <= wr_ent;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q <= slot_mem[rd_idx];
		end
	end

	// hold the entry written on the read edge when it is the one read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (acc) begin
			fwd_q <= wr_en && (wr_idx == rd_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			fwd_ent_q <= wr_ent;
		end
	end

	assign rd_ent = fwd_q ? fwd_ent_q : rd_q;

	// ------------------------------------------------------------------
	// Slot flags and free-slot search
	// ------------------------------------------------------------------
	logic [SLOTS-1:0] in_use_q;
	free_slot_t       free;

	kht_free_find u_find (
		.clk    (clk),
		.arst_n (arst_n),
		.in_use (in_use_q),
		.free   (free)
	);

	// ------------------------------------------------------------------
	// Stage 1: handle check. Valid when not special, index inside the
	// table, slot in use and equal to the stored handle with the no-close
	// flag ignored.
	// ------------------------------------------------------------------
	logic [HDL_W-1:0] h_s1;
	logic             idx_ok;
	logic             hit;

	assign h_s1   = req_s1.handle_in;
	assign idx_ok = ({1'b0, h_s1[IDXF_W-1:0]} < 16'(SLOTS));
	assign hit    = !h_s1[HDL_W-1] && idx_ok && in_use_q[h_s1[SLOT_W-1:0]]
	             && ({rd_ent.handle[HDL_W-1:IDXF_W+1], rd_ent.handle[IDXF_W-1:0]}
	              == {h_s1[HDL_W-1:IDXF_W+1], h_s1[IDXF_W-1:0]});

	logic                vld_s2;
	logic [1:0]          op_s2;
	logic [HDL_W-1:0]    h_s2;
	logic [OBJ_BITS-1:0] obj_s2;
	logic [OBJ_BITS-1:0] fobj_s2;
	logic                hit_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			op_s2   <= req_s1.opcode;
			h_s2    <= h_s1;
			obj_s2  <= req_s1.object_ref[OBJ_BITS-1:0];
			fobj_s2 <= rd_ent.obj;
			hit_s2  <= hit;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: result, write-back, flag and counter update
	// ------------------------------------------------------------------
	logic [INST_W-1:0] inst_q;
	logic [INST_W-1:0] inst_nxt;
	logic [HDL_W-1:0]  new_h;
	logic              claim;
	logic              drop;
	rsp_t              rsp_d;
	rsp_t              rsp_q;
	logic              done_q;

	assign inst_nxt = inst_q + INST_W'(1);
	assign new_h    = {1'b0, owner_q, inst_nxt, 1'b0, IDXF_W'(free.idx)};
	assign wr_idx   = free.idx;
	assign wr_en    = vld_s2 && claim;

	always_comb begin
		rsp_d      = '0;
		claim      = 1'b0;
		drop       = 1'b0;
		wr_ent     = '{handle: new_h, obj: obj_s2};
		unique case (op_s2)
			OP_ADD: begin
				if (free.found) begin
					claim             = 1'b1;
					rsp_d.handle_out  = new_h;
					rsp_d.object_out  = OBJF_W'(obj_s2);
					rsp_d.ref_taken   = 1'b1;
				end else begin
					rsp_d.status = ST_FULL;
				end
			end
			OP_DUP: begin
				wr_ent.obj = fobj_s2;
				priority if (h_s2[HDL_W-1]) begin
					rsp_d.status = ST_BAD;
				end else if (!owner_q && (h_s2[HDL_W-1:HDL_W-2] != 2'b01)) begin
					rsp_d.status = ST_NOT_LOCAL;
				end else if (!hit_s2) begin
					rsp_d.status = ST_BAD;
				end else begin
					rsp_d.object_out = OBJF_W'(fobj_s2);
					if (free.found) begin
						claim            = 1'b1;
						rsp_d.handle_out = new_h;
						rsp_d.ref_taken  = 1'b1;
					end else begin
						rsp_d.status = ST_FULL;
					end
				end
			end
			OP_LOOKUP: begin
				if (hit_s2) begin
					rsp_d.object_out = OBJF_W'(fobj_s2);
				end else begin
					rsp_d.status = ST_BAD;
				end
			end
			OP_CLOSE: begin
				if (hit_s2) begin
					drop              = 1'b1;
					rsp_d.object_out  = OBJF_W'(fobj_s2);
					rsp_d.ref_dropped = 1'b1;
				end else begin
					rsp_d.status = ST_BAD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			inst_q   <= '0;
		end else if (vld_s2) begin
			if (claim) begin
				in_use_q[free.idx] <= 1'b1;
				inst_q             <= inst_nxt;
			end
			if (drop) begin
				in_use_q[h_s2[SLOT_W-1:0]] <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register: one-cycle strobe, receiver cannot stall
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

>>> rtl/kht_checker.sv
// ----------------------------------------------------------------------------
// kht_checker
// Port-level checks of the handle table, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kht_checker
	import kht_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire rsp_t rsp
);

	// an accepted word keeps the block busy for exactly one cycle
	`KHT_ASSERT(a_busy_after_acc, clk, arst_n, (start && !busy) |=> busy, "busy missing after accept")
	`KHT_ASSERT(a_busy_one_cycle, clk, arst_n, busy |=> !busy, "busy held longer than one cycle")

	// results are strobes, never in back-to-back cycles
	`KHT_ASSERT(a_done_spaced, clk, arst_n, done |=> !done, "result strobe in back-to-back cycles")

	// failed requests carry no handle and no reference change
	`KHT_NEVER(a_fail_clean, clk, arst_n,
		done && (rsp.status != ST_OK) && (rsp.ref_taken || rsp.ref_dropped || (rsp.handle_out != '0)),
		"failed result carries a handle or reference change")

endmodule

bind kernel_handle_table kht_checker u_kht_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the kernel handle table. A directed table covers
// reset state, handle extremes, special and stale handles, the locality
// check and owner switching; random phases then fill, drain and churn the
// table. Every result word is checked field by field against a typed-in
// expected word or an in-bench model of the slot table.
// ----------------------------------------------------------------------------

module tb_top;
	import kht_pkg::*;

	localparam logic [31:0] NOCLOSE_FLAG = 32'h0000_8000;
	localparam int          PHASES       = 8;
	localparam int          PHASE_WORDS  = 100;

	typedef enum logic {ROW_WORD, ROW_OWNER} row_kind_e;
	typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

	typedef struct {
		row_kind_e kind;
		req_t      word;
		bit        typed;   // expected word typed in below, else from the model
		rsp_t      exp;
	} row_t;

	// ------------------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// ------------------------------------------------------------------------
	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start   = 1'b0;
	req_t        req     = '0;
	logic        busy;
	logic        done;
	rsp_t        rsp;

	kernel_handle_table uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Slot table model: own copy of flags, objects, handles, counter, owner
	// ------------------------------------------------------------------------
	bit                  live     [SLOTS];
	bit                  ever_set [SLOTS];   // slot holds a handle from some claim
	logic [OBJ_BITS-1:0] slot_obj [SLOTS];
	logic [31:0]         slot_hdl [SLOTS];
	logic [INST_W-1:0]   inst_ctr;
	logic                owner_thread;

	rsp_t pending_rsp[$];   // result words still owed by the DUT, oldest first
	int   errors;

	// Valid when not special, index in range, slot live, and handle matches the
	// stored one with the no-close flag masked off.
	function automatic bit slot_for(input logic [31:0] h, output int idx);
		idx = int'(h[IDXF_W-1:0]);
		if (h[31])
			return 1'b0;
		if (idx >= SLOTS)
			return 1'b0;
		if (!live[idx])
			return 1'b0;
		return (slot_hdl[idx] & ~NOCLOSE_FLAG) == (h & ~NOCLOSE_FLAG);
	endfunction

	// Take the lowest free slot; advance the counter only on success.
	function automatic bit claim_slot(input logic [OBJ_BITS-1:0] obj, output logic [31:0] h);
		int i;
		for (i = 0; i < SLOTS; i++) begin
			if (!live[i]) begin
				inst_ctr    = inst_ctr + 1'b1;
				h           = {1'b0, owner_thread, inst_ctr, 1'b0, IDXF_W'(i)};
				live[i]     = 1'b1;
				ever_set[i] = 1'b1;
				slot_obj[i] = obj;
				slot_hdl[i] = h;
				return 1'b1;
			end
		end
		h = '0;
		return 1'b0;
	endfunction

	// Apply one request word to the model and return the result word it owes.
	function automatic rsp_t table_step(input req_t w);
		rsp_t        r;
		int          idx;
		logic [31:0] h;
		r = '0;
		case (w.opcode)
			OP_ADD: begin
				if (claim_slot(w.object_ref[OBJ_BITS-1:0], h)) begin
					r.handle_out = h;
					r.object_out = w.object_ref;
					r.ref_taken  = 1'b1;
				end else begin
					r.status = ST_FULL;
				end
			end
			OP_DUP: begin
				if (w.handle_in[31]) begin
					r.status = ST_BAD;
				end else if (!owner_thread && w.handle_in[31:30] != 2'b01) begin
					r.status = ST_NOT_LOCAL;
				end else if (!slot_for(w.handle_in, idx)) begin
					r.status = ST_BAD;
				end else begin
					// object reported even when the table turns out full
					r.object_out = slot_obj[idx];
					if (claim_slot(slot_obj[idx], h)) begin
						r.handle_out = h;
						r.ref_taken  = 1'b1;
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			default: begin
				// lookup and close share the handle check
				if (!slot_for(w.handle_in, idx)) begin
					r.status = ST_BAD;
				end else begin
					r.object_out = slot_obj[idx];
					if (w.opcode == OP_CLOSE) begin
						live[idx]     = 1'b0;
						r.ref_dropped = 1'b1;
					end
				end
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	function automatic row_t mk_row(input row_kind_e kind, input logic [1:0] op,
			input logic [31:0] h, input logic [15:0] obj, input bit typed,
			input logic [1:0] st, input logic [31:0] hout, input logic [15:0] oout,
			input logic tk, input logic dr);
		row_t r;
		r.kind            = kind;
		r.word.opcode     = op;
		r.word.handle_in  = h;
		r.word.object_ref = obj;
		r.typed           = typed;
		r.exp.status      = st;
		r.exp.handle_out  = hout;
		r.exp.object_out  = oout;
		r.exp.ref_taken   = tk;
		r.exp.ref_dropped = dr;
		return r;
	endfunction

	// Idle bursts before about one word in three; none when quiet.
	function automatic int idle_gap(input bit quiet);
		if (quiet || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(1, 12);
	endfunction

	// Mostly live handles (random no-close flag, now and then a flipped
	// instance or owner bit), some stale handles of freed slots, rest noise.
	function automatic logic [31:0] pick_handle();
		int          roll;
		int          k;
		int          n;
		logic [31:0] h;
		roll = $urandom_range(0, 99);
		k    = $urandom_range(0, SLOTS - 1);
		h    = $urandom();
		if (roll < 80) begin
			for (n = 0; n < SLOTS; n++) begin
				if (roll < 65 ? live[k] : (ever_set[k] && !live[k])) begin
					h = slot_hdl[k];
					if ($urandom_range(0, 1) != 0)
						h = h | NOCLOSE_FLAG;
					if ($urandom_range(0, 9) == 0)
						h = h ^ (32'h1 << $urandom_range(16, 30));
					return h;
				end
				k = (k + 1) % SLOTS;
			end
		end else if (roll < 90) begin
			// noise with an in-range index
			h[IDXF_W-1:0] = IDXF_W'($urandom_range(0, SLOTS - 1));
		end
		return h;
	endfunction

	// Present one word, hold it until accepted, then log what it owes.
	// start stays high on return so back-to-back words need no extra edge.
	task automatic issue(input req_t w, input int gap, input bit typed,
			input rsp_t typed_rsp, output rsp_t pred);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pred = table_step(w);
		pending_rsp.push_back(typed ? typed_rsp : pred);
	endtask

	// Register writes only with the table idle: drop start, let every owed
	// result arrive, then write owner_is_thread and read it back.
	task automatic set_owner(input logic val);
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		// setup phase of the write
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_AW'(REG_OWNER) << 2;
		pwdata  <= {31'b0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		owner_thread = val;
		// read back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {31'b0, val})
			flag_mismatch("owner_is_thread readback", prdata, {31'b0, val});
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Result checker: each strobed word is matched against the oldest one owed
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				flag_mismatch("unexpected result word", rsp.handle_out, '0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					flag_mismatch("status", 32'(rsp.status), 32'(want.status));
				if (rsp.handle_out !== want.handle_out)
					flag_mismatch("handle_out", rsp.handle_out, want.handle_out);
				if (rsp.object_out !== want.object_out)
					flag_mismatch("object_out", 32'(rsp.object_out), 32'(want.object_out));
				if (rsp.ref_taken !== want.ref_taken)
					flag_mismatch("ref_taken", 32'(rsp.ref_taken), 32'(want.ref_taken));
				if (rsp.ref_dropped !== want.ref_dropped)
					flag_mismatch("ref_dropped", 32'(rsp.ref_dropped), 32'(want.ref_dropped));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	row_t script[$];

	initial begin
		rsp_t        pred;
		rsp_t        none;
		req_t        w;
		row_t        r;
		mix_e        mix;
		bit          quiet;
		int          roll;
		int          ph;
		int          n;

		errors       = 0;
		inst_ctr     = '0;
		owner_thread = 1'b0;
		none         = '0;
		foreach (live[i]) begin
			live[i]     = 1'b0;
			ever_set[i] = 1'b0;
			slot_obj[i] = '0;
			slot_hdl[i] = '0;
		end

		// Directed table. Owner starts as a process (reset value).
		script.push_back(mk_row(ROW_WORD, OP_LOOKUP, 32'h0000_0000, 16'h0000, 1,
			ST_BAD, 32'h0, 16'h0, 0, 0));                           // empty table
		script.push_back(mk_row(ROW_WORD, OP_ADD, 32'h0, 16'hFFFF, 1,
			ST_OK, 32'h0001_0000, 16'hFFFF, 1, 0));                 // max object
		script.push_back(mk_row(ROW_WORD, OP_ADD, 32'h0, 16'h0000, 1,
			ST_OK, 32'h0002_0001, 16'h0000, 1, 0));                 // zero object
		script.push_back(mk_row(ROW_WORD, OP_ADD, 32'h0, 16'h0001, 1,
			ST_OK, 32'h0003_0002, 16'h0001, 1, 0));
		script.push_back(mk_row(ROW_WORD, OP_LOOKUP, 32'h0001_0000, 16'h0, 1,
			ST_OK, 32'h0, 16'hFFFF, 0, 0));
		script.push_back(mk_row(ROW_WORD, OP_LOOKUP, 32'h0001_8000, 16'h0, 1,
			ST_OK, 32'h0, 16'hFFFF, 0, 0));                         // no-close flag ignored
		script.push_back(mk_row(ROW_WORD, OP_LOOKUP, 32'h0002_0001, 16'h0, 1,
			ST_OK, 32'h0, 16'h0000, 0, 0));
		script.push_back(mk_row(ROW_WORD, OP_LOOKUP, 32'h0001_0001, 16'h0, 1,
			ST_BAD, 32'h0, 16'h0, 0, 0));                           // wrong instance
		script.push_back(mk_row(ROW_WORD, OP_LOOKUP, 32'h8001_0000, 16'h0, 1,
			ST_BAD, 32'h0, 16'h0, 0, 0));                           // special handle
		script.push_back(mk_row(ROW_WORD, OP_DUP, 32'h8001_0000, 16'h0, 1,
			ST_BAD, 32'h0, 16'h0, 0, 0));
		script.push_back(mk_row(ROW_WORD, OP_DUP, 32'h0001_0000, 16'h0, 1,
			ST_NOT_LOCAL, 32'h0, 16'h0, 0, 0));                     // not local to process
		script.push_back(mk_row(ROW_WORD, OP_DUP, 32'hC001_0000, 16'h0, 1,
			ST_BAD, 32'h0, 16'h0, 0, 0));                           // special beats locality
		script.push_back(mk_row(ROW_WORD, OP_DUP, 32'h4001_0000, 16'h0, 1,
			ST_BAD, 32'h0, 16'h0, 0, 0));                           // local, owner bit mismatch
		script.push_back(mk_row(ROW_WORD, OP_LOOKUP, 32'h0001_0040, 16'h0, 1,
			ST_BAD, 32'h0, 16'h0, 0, 0));                           // index past table
		script.push_back(mk_row(ROW_WORD, OP_LOOKUP, 32'h0001_7FFF, 16'h0, 1,
			ST_BAD, 32'h0, 16'h0, 0, 0));                           // max index
		script.push_back(mk_row(ROW_WORD, OP_CLOSE, 32'h0002_0001, 16'h0, 1,
			ST_OK, 32'h0, 16'h0000, 0, 1));
		script.push_back(mk_row(ROW_WORD, OP_LOOKUP, 32'h0002_0001, 16'h0, 1,
			ST_BAD, 32'h0, 16'h0, 0, 0));                           // freed slot
		script.push_back(mk_row(ROW_WORD, OP_CLOSE, 32'h0002_0001, 16'h0, 1,
			ST_BAD, 32'h0, 16'h0, 0, 0));                           // double close
		script.push_back(mk_row(ROW_WORD, OP_ADD, 32'h0, 16'h1234, 1,
			ST_OK, 32'h0004_0001, 16'h1234, 1, 0));                 // reuse freed slot
		script.push_back(mk_row(ROW_WORD, OP_CLOSE, 32'h0001_8000, 16'h0, 1,
			ST_OK, 32'h0, 16'hFFFF, 0, 1));
		script.push_back(mk_row(ROW_WORD, OP_LOOKUP, 32'hFFFF_FFFF, 16'h0, 1,
			ST_BAD, 32'h0, 16'h0, 0, 0));
		script.push_back(mk_row(ROW_WORD, OP_ADD, 32'h0, 16'hA5A5, 1,
			ST_OK, 32'h0005_0000, 16'hA5A5, 1, 0));
		// thread-owned table: new handles carry the owner bit
		script.push_back(mk_row(ROW_OWNER, OP_ADD, 32'h0, 16'h0001, 0,
			ST_OK, 32'h0, 16'h0, 0, 0));
		script.push_back(mk_row(ROW_WORD, OP_ADD, 32'h0, 16'h0BEE, 1,
			ST_OK, 32'h4006_0003, 16'h0BEE, 1, 0));
		script.push_back(mk_row(ROW_WORD, OP_DUP, 32'h4006_8003, 16'h0, 1,
			ST_OK, 32'h4007_0004, 16'h0BEE, 1, 0));
		// back to process-owned: a handle with bits 31..30 = 01 still duplicates
		script.push_back(mk_row(ROW_OWNER, OP_ADD, 32'h0, 16'h0000, 0,
			ST_OK, 32'h0, 16'h0, 0, 0));
		script.push_back(mk_row(ROW_WORD, OP_DUP, 32'h4007_0004, 16'h0, 0,
			ST_OK, 32'h0, 16'h0, 0, 0));

		// Hold reset, then release it on a rising edge.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			r = script[i];
			if (r.kind == ROW_OWNER)
				set_owner(r.word.object_ref[0]);
			else
				issue(r.word, idle_gap(1'b0), r.typed, r.exp, pred);
		end

		// Random phases: each picks an owner, an op mix and an idling style.
		for (ph = 0; ph < PHASES; ph++) begin
			if (ph == 0)
				set_owner(1'b1);
			else if (ph == 1)
				set_owner(1'b0);
			else
				set_owner(1'($urandom_range(0, 1)));
			mix   = mix_e'($urandom_range(0, 2));
			// last phase runs with no idling, others now and then
			quiet = (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_WORDS; n++) begin
				roll = $urandom_range(0, 99);
				case (mix)
					MIX_FILL:  w.opcode = roll < 50 ? OP_ADD : roll < 70 ? OP_DUP :
						roll < 85 ? OP_LOOKUP : OP_CLOSE;
					MIX_DRAIN: w.opcode = roll < 15 ? OP_ADD : roll < 30 ? OP_DUP :
						roll < 50 ? OP_LOOKUP : OP_CLOSE;
					default:   w.opcode = 2'($urandom_range(0, 3));
				endcase
				w.handle_in  = pick_handle();
				w.object_ref = ($urandom_range(0, 49) == 0) ? 16'h0000 :
					16'($urandom_range(1, 16'hFFFF));
				issue(w, idle_gap(quiet), 1'b0, none, pred);
			end
		end

		// Drain: drop start, wait for every owed word, then idle before finishing.
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Watchdog: a time-out far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
